/* rtl/cpd_pkg.sv */
// Shared types and constants for the cache packet deframer.
package cpd_pkg;

    localparam int unsigned HDR_BYTES = 20;
    localparam int unsigned HC_W = 5;
    localparam logic [HC_W-1:0] HDR_LAST = HC_W'(HDR_BYTES - 1);

    localparam logic [HC_W-1:0] POS_ID_HI = 5'd0;
    localparam logic [HC_W-1:0] POS_ID_LO = 5'd1;
    localparam logic [HC_W-1:0] POS_OP = 5'd2;
    localparam logic [HC_W-1:0] POS_RES = 5'd3;
    localparam logic [HC_W-1:0] POS_FLAGS = 5'd4;
    localparam logic [HC_W-1:0] POS_MSG_HI = 5'd5;
    localparam logic [HC_W-1:0] POS_MSG_LO = 5'd6;
    localparam logic [HC_W-1:0] POS_PAD = 5'd7;
    localparam logic [HC_W-1:0] POS_TIME_LO = 5'd8;
    localparam logic [HC_W-1:0] POS_KEY_LO = 5'd12;
    localparam logic [HC_W-1:0] POS_VAL_LO = 5'd16;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_HDR_DONE = 3'd1;
    localparam logic [2:0] KIND_MESSAGE = 3'd2;
    localparam logic [2:0] KIND_KEY = 3'd3;
    localparam logic [2:0] KIND_VALUE = 3'd4;
    localparam logic [2:0] KIND_IGNORED = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] packet_id;
        logic [7:0]  op_code;
        logic [7:0]  result_code;
        logic [7:0]  flag_bits;
        logic [15:0] message_length;
        logic [31:0] time_stamp;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic        packet_done;
        logic        truncated;
    } out_t;

endpackage

/* rtl/cpd_parse.sv */
// Deframer parse state and per-byte result logic.
module cpd_parse (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  cpd_pkg::in_t  item,
    output cpd_pkg::out_t result
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_MSG    = 3'd1,
        PH_KEY    = 3'd2,
        PH_VAL    = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    logic [cpd_pkg::HC_W-1:0] header_count_reg, header_count_next, hc_upd;
    phase_t      phase_reg, phase_next, phase_upd, sec_start;
    logic [31:0] remaining_reg, remaining_next, rem_upd;
    logic [15:0] id_reg, id_next, id_upd;
    logic [7:0]  op_reg, op_next, op_upd;
    logic [7:0]  res_reg, res_next, res_upd;
    logic [7:0]  flags_reg, flags_next, flags_upd;
    logic [15:0] msg_len_reg, msg_len_next, msg_upd;
    logic [31:0] time_reg, time_next, time_upd;
    logic [31:0] key_len_reg, key_len_next, key_upd;
    logic [31:0] value_len_reg, value_len_next, val_upd;
    logic        enter;
    logic [2:0]  kind;
    logic [7:0]  pay;
    logic [7:0]  b;

    assign b = item.data_byte;

    always_comb begin
        hc_upd    = header_count_reg;
        phase_upd = phase_reg;
        rem_upd   = remaining_reg;
        id_upd    = id_reg;
        op_upd    = op_reg;
        res_upd   = res_reg;
        flags_upd = flags_reg;
        msg_upd   = msg_len_reg;
        time_upd  = time_reg;
        key_upd   = key_len_reg;
        val_upd   = value_len_reg;
        enter     = 1'b0;
        sec_start = PH_DONE;
        kind      = cpd_pkg::KIND_IGNORED;
        pay       = 8'd0;

        case (phase_reg)
            PH_HEADER: begin
                if (header_count_reg <= cpd_pkg::POS_ID_LO) begin
                    id_upd = {id_reg[7:0], b};
                end else if (header_count_reg == cpd_pkg::POS_OP) begin
                    op_upd = b;
                end else if (header_count_reg == cpd_pkg::POS_RES) begin
                    res_upd = b;
                end else if (header_count_reg == cpd_pkg::POS_FLAGS) begin
                    flags_upd = b;
                end else if (header_count_reg <= cpd_pkg::POS_MSG_LO) begin
                    msg_upd = {msg_len_reg[7:0], b};
                end else if (header_count_reg == cpd_pkg::POS_PAD) begin
                    // drop padding byte
                end else if (header_count_reg < cpd_pkg::POS_KEY_LO) begin
                    time_upd = {time_reg[23:0], b};
                end else if (header_count_reg < cpd_pkg::POS_VAL_LO) begin
                    key_upd = {key_len_reg[23:0], b};
                end else begin
                    val_upd = {value_len_reg[23:0], b};
                end
                hc_upd = header_count_reg + cpd_pkg::HC_W'(1);
                if (header_count_reg == cpd_pkg::HDR_LAST) begin
                    kind      = cpd_pkg::KIND_HDR_DONE;
                    enter     = 1'b1;
                    sec_start = PH_MSG;
                end else begin
                    kind = cpd_pkg::KIND_HEADER;
                end
            end
            PH_MSG: begin
                kind      = cpd_pkg::KIND_MESSAGE;
                pay       = b;
                rem_upd   = remaining_reg - 32'd1;
                enter     = (remaining_reg == 32'd1);
                sec_start = PH_KEY;
            end
            PH_KEY: begin
                kind      = cpd_pkg::KIND_KEY;
                pay       = b;
                rem_upd   = remaining_reg - 32'd1;
                enter     = (remaining_reg == 32'd1);
                sec_start = PH_VAL;
            end
            PH_VAL: begin
                kind      = cpd_pkg::KIND_VALUE;
                pay       = b;
                rem_upd   = remaining_reg - 32'd1;
                enter     = (remaining_reg == 32'd1);
                sec_start = PH_DONE;
            end
            default: begin
                kind = cpd_pkg::KIND_IGNORED;
            end
        endcase

        if (enter) begin
            if (sec_start == PH_MSG && msg_upd != 16'd0) begin
                phase_upd = PH_MSG;
                rem_upd   = {16'd0, msg_upd};
            end else if ((sec_start == PH_MSG || sec_start == PH_KEY) && key_upd != 32'd0) begin
                phase_upd = PH_KEY;
                rem_upd   = key_upd;
            end else if (sec_start != PH_DONE && val_upd != 32'd0) begin
                phase_upd = PH_VAL;
                rem_upd   = val_upd;
            end else begin
                phase_upd = PH_DONE;
                rem_upd   = 32'd0;
            end
        end

        result.kind           = kind;
        result.payload_byte   = pay;
        result.packet_id      = id_upd;
        result.op_code        = op_upd;
        result.result_code    = res_upd;
        result.flag_bits      = flags_upd;
        result.message_length = msg_upd;
        result.time_stamp     = time_upd;
        result.key_length     = key_upd;
        result.value_length   = val_upd;
        result.packet_done    = item.last_byte && (phase_upd == PH_DONE);
        result.truncated      = item.last_byte && (phase_upd != PH_DONE);

        if (item.last_byte) begin
            header_count_next = '0;
            phase_next        = PH_HEADER;
            remaining_next    = 32'd0;
            id_next           = 16'd0;
            op_next           = 8'd0;
            res_next          = 8'd0;
            flags_next        = 8'd0;
            msg_len_next      = 16'd0;
            time_next         = 32'd0;
            key_len_next      = 32'd0;
            value_len_next    = 32'd0;
        end else begin
            header_count_next = hc_upd;
            phase_next        = phase_upd;
            remaining_next    = rem_upd;
            id_next           = id_upd;
            op_next           = op_upd;
            res_next          = res_upd;
            flags_next        = flags_upd;
            msg_len_next      = msg_upd;
            time_next         = time_upd;
            key_len_next      = key_upd;
            value_len_next    = val_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg <= '0;
            phase_reg        <= PH_HEADER;
            remaining_reg    <= 32'd0;
            id_reg           <= 16'd0;
            op_reg           <= 8'd0;
            res_reg          <= 8'd0;
            flags_reg        <= 8'd0;
            msg_len_reg      <= 16'd0;
            time_reg         <= 32'd0;
            key_len_reg      <= 32'd0;
            value_len_reg    <= 32'd0;
        end else if (fire) begin
            header_count_reg <= header_count_next;
            phase_reg        <= phase_next;
            remaining_reg    <= remaining_next;
            id_reg           <= id_next;
            op_reg           <= op_next;
            res_reg          <= res_next;
            flags_reg        <= flags_next;
            msg_len_reg      <= msg_len_next;
            time_reg         <= time_next;
            key_len_reg      <= key_len_next;
            value_len_reg    <= value_len_next;
        end
    end

endmodule

/* rtl/cache_packet_deframer.sv */
// Top level of the cache packet deframer: input register, parser, result register.
// A byte accepted on s_ is held in the input register, parsed, and its result registered onto m_.
// Throughput: one byte per clock; s_ready falls only while both registers hold
// transactions and m_ready is low.
// Reset: aresetn synchronous, active low; clears both valid flags and the parser
// state to the header phase with all header fields zero.
module cache_packet_deframer (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cpd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output cpd_pkg::out_t m_data
);

    logic          in_valid_reg;
    cpd_pkg::in_t  in_data_reg;
    logic          out_valid_reg;
    cpd_pkg::out_t out_data_reg;
    cpd_pkg::out_t result;
    logic          fire;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    cpd_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= result;
        end
    end

    a_done_trunc_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.packet_done && m_data.truncated))
        else $error("packet_done and truncated both set");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.kind <= cpd_pkg::KIND_IGNORED))
        else $error("kind out of range");

    a_pay_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.kind == cpd_pkg::KIND_HEADER
            || m_data.kind == cpd_pkg::KIND_HDR_DONE
            || m_data.kind == cpd_pkg::KIND_IGNORED)) |-> (m_data.payload_byte == 8'd0))
        else $error("payload byte set outside payload sections");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("pending transaction lost while stalled");

endmodule
